@@ design/pidsc_pkg.sv @@
// Package for the PID speed controller: shared widths, constants, reset values
// and the state types of the sequencer and the serial divider. No dependencies.
package pidsc_pkg;

    // Default values of the top-level parameters.
    localparam int SPEED_WIDTH_DEF   = 20;
    localparam int STEP_WIDTH_DEF    = 24;
    localparam int OUT_FRAC_BITS_DEF = 30;

    // Fixed formats.
    localparam int GAIN_W     = 32;
    localparam int DT_FRAC    = 24;
    localparam int GAIN_FRAC  = 32;
    localparam int DERIV_FRAC = 48;
    localparam int INTEG_W    = 40;
    localparam int DRIVE_W    = 32;

    // Term magnitudes saturate at 2^(TERM_W-1).
    localparam int TERM_W = 57;
    localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

    // Quotient bits retired per divider cycle.
    localparam int DIV_BITS = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 32'd4294967;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 32'd17179869;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 32'd2814750;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL_D,
        S_MUL_P,
        S_MUL_X,
        S_RND_P,
        S_MUL_IL,
        S_MUL_IH,
        S_ACC_I,
        S_RND_I,
        S_INTEG,
        S_PI,
        S_SUM
    } t_seq_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIN
    } t_div_state;

endpackage

@@ design/pidsc_chan_if.sv @@
// Valid/ready channel interfaces of the PID speed controller.
// Depends on pidsc_pkg for default widths.
interface pidsc_in_if #(
    parameter int SPEED_WIDTH = pidsc_pkg::SPEED_WIDTH_DEF,
    parameter int STEP_WIDTH  = pidsc_pkg::STEP_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] setpoint;
    logic signed [SPEED_WIDTH-1:0] measured;
    logic [STEP_WIDTH-1:0]         time_step;
    logic                          limit_active;

    modport source (
        output valid, setpoint, measured, time_step, limit_active,
        input  ready
    );
    modport sink (
        input  valid, setpoint, measured, time_step, limit_active,
        output ready
    );
endinterface

interface pidsc_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pidsc_pkg::DRIVE_W-1:0]     drive;
    logic                                     clamped;

    modport source (
        output valid, drive, clamped,
        input  ready
    );
    modport sink (
        input  valid, drive, clamped,
        output ready
    );
endinterface

@@ design/pidsc_mul.sv @@
// Shared unsigned multiplier with a registered product.
// No package dependencies.
module pidsc_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_prod
);

    logic [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ design/pidsc_div.sv @@
// Serial restoring divider, DIV_BITS quotient bits per cycle, with
// round-half-up and saturation of the quotient. Depends on pidsc_pkg.
module pidsc_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pidsc_pkg::TERM_W-1:0]   o_quot
);

    localparam int NUMP_W = ((NUM_W + pidsc_pkg::DIV_BITS - 1) / pidsc_pkg::DIV_BITS)
                            * pidsc_pkg::DIV_BITS;
    localparam int ITER   = NUMP_W / pidsc_pkg::DIV_BITS;
    localparam int CNT_W  = $clog2(ITER + 1);
    localparam int CMP_W  = (NUMP_W + 1 > pidsc_pkg::TERM_W) ? NUMP_W + 1 : pidsc_pkg::TERM_W;
    localparam logic [CMP_W-1:0] CMP_LIMIT = CMP_W'(pidsc_pkg::TERM_LIMIT);

    pidsc_pkg::t_div_state r_state, n_state;
    logic                          r_done, n_done;
    logic [NUMP_W-1:0]             r_num, n_num;
    logic [DEN_W-1:0]              r_den, n_den;
    logic [DEN_W-1:0]              r_rem, n_rem;
    logic [NUMP_W-1:0]             r_quot, n_quot;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [pidsc_pkg::TERM_W-1:0]  r_result, n_result;

    logic [DEN_W:0]                t_trial;
    logic [DEN_W-1:0]              t_rem;
    logic [NUMP_W-1:0]             t_num;
    logic [NUMP_W-1:0]             t_quot;
    logic                          t_round;
    logic [CMP_W-1:0]              t_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidsc_pkg::DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_quot   = r_quot;
        n_cnt    = r_cnt;
        n_result = r_result;
        t_trial  = '0;
        t_rem    = r_rem;
        t_num    = r_num;
        t_quot   = r_quot;
        t_round  = 1'b0;
        t_qr     = '0;
        case (r_state)
            pidsc_pkg::DIV_IDLE: begin
                if (i_start) begin
                    n_num   = NUMP_W'(i_num);
                    n_den   = i_den;
                    n_rem   = '0;
                    n_quot  = '0;
                    n_cnt   = CNT_W'(ITER);
                    n_state = pidsc_pkg::DIV_RUN;
                end
            end
            pidsc_pkg::DIV_RUN: begin
                for (int k = 0; k < pidsc_pkg::DIV_BITS; k++) begin
                    t_trial = {t_rem, t_num[NUMP_W-1]};
                    t_num   = t_num << 1;
                    if (t_trial >= {1'b0, r_den}) begin
                        t_rem  = DEN_W'(t_trial - {1'b0, r_den});
                        t_quot = {t_quot[NUMP_W-2:0], 1'b1};
                    end else begin
                        t_rem  = t_trial[DEN_W-1:0];
                        t_quot = {t_quot[NUMP_W-2:0], 1'b0};
                    end
                end
                n_num  = t_num;
                n_rem  = t_rem;
                n_quot = t_quot;
                n_cnt  = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = pidsc_pkg::DIV_FIN;
                end
            end
            pidsc_pkg::DIV_FIN: begin
                // Round half up: the remainder is at least half the divisor.
                t_round  = ({r_rem, 1'b0} >= {1'b0, r_den});
                t_qr     = CMP_W'(r_quot) + CMP_W'(t_round);
                n_result = (t_qr > CMP_LIMIT) ? pidsc_pkg::TERM_LIMIT
                                              : pidsc_pkg::TERM_W'(t_qr);
                n_done   = 1'b1;
                n_state  = pidsc_pkg::DIV_IDLE;
            end
            default: begin
                n_state = pidsc_pkg::DIV_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != pidsc_pkg::DIV_IDLE);
    assign o_done = r_done;
    assign o_quot = r_result;

endmodule

@@ design/pid_speed_controller_top.sv @@
// Top level of the PID speed controller with anti-windup.
// Depends on pidsc_pkg, pidsc_chan_if, pidsc_mul and pidsc_div.
//
// Usage: one input beat on i_in (setpoint, measured, time_step, limit_active)
// yields one output beat on o_out (drive in Q1.30 at default settings, and
// clamped). Gains are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while the block is idle, which the block itself does
// not enforce. An index beyond the three gains is ignored.
// An item runs through a sequencer that drives one shared multiplier for the
// derivative, proportional, error-times-step and two integral partial
// products, while a serial divider (two quotient bits per cycle) forms the
// derivative quotient. The divider run sets the time from acceptance to a
// valid result; its numerator width NUM_W is SPEED_WIDTH + 34 plus any extra
// fraction bits above 24. i_in.ready is high only while the sequencer is
// idle, so one item is in flight at a time.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result waits in the last
// sequencer step until the register frees up.
// Synchronous reset restores the gain reset values and clears the integrator,
// the stored error and all valid flags.
module pid_speed_controller_top #(
    parameter int SPEED_WIDTH   = pidsc_pkg::SPEED_WIDTH_DEF,
    parameter int STEP_WIDTH    = pidsc_pkg::STEP_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = pidsc_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pidsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pidsc_pkg::GAIN_W-1:0]      i_cfg_data,
    pidsc_in_if.sink                          i_in,
    pidsc_out_if.source                       o_out
);

    localparam int GW      = pidsc_pkg::GAIN_W;
    localparam int ERR_W   = SPEED_WIDTH + 1;
    localparam int DE_W    = SPEED_WIDTH + 2;
    localparam int MA_W    = (DE_W > GW) ? DE_W : GW;
    localparam int MB_W    = (STEP_WIDTH > GW) ? STEP_WIDTH : GW;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int X_W     = 2 * MA_W;
    localparam int ACC_W   = 2 * MA_W + MB_W;
    localparam int DSHIFT  = pidsc_pkg::DERIV_FRAC - pidsc_pkg::DT_FRAC;
    localparam int KL      = (OUT_FRAC_BITS > DSHIFT) ? OUT_FRAC_BITS - DSHIFT : 0;
    localparam int KR      = (OUT_FRAC_BITS > DSHIFT) ? 0 : DSHIFT - OUT_FRAC_BITS;
    localparam int NUM_W   = DE_W + GW + KL;
    localparam int DEN_W   = STEP_WIDTH + KR;
    localparam int SH_P    = pidsc_pkg::GAIN_FRAC - OUT_FRAC_BITS;
    localparam int SH_I    = pidsc_pkg::DT_FRAC + pidsc_pkg::GAIN_FRAC - OUT_FRAC_BITS;
    localparam int TW      = pidsc_pkg::TERM_W;
    localparam int STERM_W = TW + 1;
    localparam int SUM_W   = STERM_W + 1;
    localparam int IW      = pidsc_pkg::INTEG_W;
    localparam int DW      = pidsc_pkg::DRIVE_W;

    localparam logic [ACC_W:0] RND_BIAS_P = (ACC_W+1)'({1'b1, {(SH_P-1){1'b0}}});
    localparam logic [ACC_W:0] RND_BIAS_I = (ACC_W+1)'({1'b1, {(SH_I-1){1'b0}}});
    localparam logic [ACC_W:0] RND_LIMIT  = (ACC_W+1)'(pidsc_pkg::TERM_LIMIT);
    localparam logic signed [SUM_W-1:0] IMAX = SUM_W'({1'b0, {(IW-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] IMIN = -(SUM_W'({1'b1, {(IW-1){1'b0}}}));
    localparam logic signed [SUM_W-1:0] SUM_ONE     = SUM_W'({1'b1, {OUT_FRAC_BITS{1'b0}}});
    localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_ONE;
    localparam logic signed [DW-1:0] DRIVE_ONE     = DW'(SUM_ONE);
    localparam logic signed [DW-1:0] DRIVE_NEG_ONE = DW'(SUM_NEG_ONE);

    pidsc_pkg::t_seq_state r_state, n_state;

    // Configuration and persistent state.
    logic [GW-1:0]               r_gain_prop, r_gain_integ, r_gain_deriv;
    logic signed [IW-1:0]        r_integrator;
    logic signed [ERR_W-1:0]     r_last_err;

    // Per-item working registers.
    logic signed [ERR_W-1:0]     r_err;
    logic [STEP_WIDTH-1:0]       r_dt;
    logic                        r_lim;
    logic [ERR_W-1:0]            r_em;
    logic                        r_eneg;
    logic [DE_W-1:0]             r_dem;
    logic                        r_dneg;
    logic [X_W-1:0]              r_x;
    logic [ACC_W-1:0]            r_acc;
    logic signed [STERM_W-1:0]   r_p;
    logic signed [STERM_W-1:0]   r_inc;
    logic signed [IW-1:0]        r_integ;
    logic signed [SUM_W-1:0]     r_pi;
    logic                        r_d_valid;

    // Output register.
    logic                        r_out_valid;
    logic signed [DW-1:0]        r_drive;
    logic                        r_clamped;

    logic signed [SPEED_WIDTH-1:0] w_sp, w_pv;
    logic [STEP_WIDTH-1:0]       w_dt;
    logic signed [DE_W-1:0]      w_de;
    logic [MA_W-1:0]             w_mul_a;
    logic [MB_W-1:0]             w_mul_b;
    logic [PROD_W-1:0]           w_prod;
    logic                        w_div_start;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [TW-1:0]               w_div_quot;
    logic                        w_sel_i;
    logic [ACC_W:0]              w_rnd_sum;
    logic [ACC_W:0]              w_rnd_shr;
    logic [TW-1:0]               w_rnd_mag;
    logic signed [STERM_W-1:0]   w_rnd_term;
    logic signed [SUM_W-1:0]     w_isum;
    logic signed [SUM_W-1:0]     w_isat;
    logic signed [STERM_W-1:0]   w_dterm;
    logic signed [SUM_W-1:0]     w_sum;
    logic                        w_clamp_hi, w_clamp_lo, w_clamp;
    logic                        w_accept;
    logic                        w_fire;

    pidsc_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    pidsc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (NUM_W'(w_prod[DE_W+GW-1:0]) << KL),
        .i_den   (DEN_W'(r_dt) << KR),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_sp = SPEED_WIDTH'(i_in.setpoint);
    assign w_pv = SPEED_WIDTH'(i_in.measured);
    assign w_dt = STEP_WIDTH'(i_in.time_step);

    assign i_in.ready = (r_state == pidsc_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_de = DE_W'(r_err) - DE_W'(r_last_err);

    // Shared round-and-saturate step for the proportional term and the
    // integral increment; both take the sign of the error.
    assign w_sel_i   = (r_state == pidsc_pkg::S_RND_I);
    assign w_rnd_sum = {1'b0, r_acc} + (w_sel_i ? RND_BIAS_I : RND_BIAS_P);
    assign w_rnd_shr = w_sel_i ? (w_rnd_sum >> SH_I) : (w_rnd_sum >> SH_P);
    assign w_rnd_mag = (w_rnd_shr > RND_LIMIT) ? pidsc_pkg::TERM_LIMIT : w_rnd_shr[TW-1:0];
    assign w_rnd_term = r_eneg ? -STERM_W'(w_rnd_mag) : STERM_W'(w_rnd_mag);

    assign w_isum = SUM_W'(r_integrator) + SUM_W'(r_inc);
    assign w_isat = (w_isum > IMAX) ? IMAX : ((w_isum < IMIN) ? IMIN : w_isum);

    assign w_dterm    = r_dneg ? -STERM_W'(w_div_quot) : STERM_W'(w_div_quot);
    assign w_sum      = r_pi + SUM_W'(w_dterm);
    assign w_clamp_hi = (w_sum > SUM_ONE);
    assign w_clamp_lo = (w_sum < SUM_NEG_ONE);
    assign w_clamp    = w_clamp_hi || w_clamp_lo;

    assign w_fire = (r_state == pidsc_pkg::S_SUM) && r_d_valid
                    && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        case (r_state)
            pidsc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = pidsc_pkg::S_LOAD;
                end
            end
            pidsc_pkg::S_LOAD: begin
                n_state = pidsc_pkg::S_MUL_D;
            end
            pidsc_pkg::S_MUL_D: begin
                w_mul_a = MA_W'(r_dem);
                w_mul_b = MB_W'(r_gain_deriv);
                n_state = pidsc_pkg::S_MUL_P;
            end
            pidsc_pkg::S_MUL_P: begin
                // The derivative product is in the multiplier register now.
                w_mul_a     = MA_W'(r_em);
                w_mul_b     = MB_W'(r_gain_prop);
                w_div_start = 1'b1;
                n_state     = pidsc_pkg::S_MUL_X;
            end
            pidsc_pkg::S_MUL_X: begin
                w_mul_a = MA_W'(r_em);
                w_mul_b = MB_W'(r_dt);
                n_state = pidsc_pkg::S_RND_P;
            end
            pidsc_pkg::S_RND_P: begin
                n_state = pidsc_pkg::S_MUL_IL;
            end
            pidsc_pkg::S_MUL_IL: begin
                w_mul_a = r_x[MA_W-1:0];
                w_mul_b = MB_W'(r_gain_integ);
                n_state = pidsc_pkg::S_MUL_IH;
            end
            pidsc_pkg::S_MUL_IH: begin
                w_mul_a = r_x[X_W-1:MA_W];
                w_mul_b = MB_W'(r_gain_integ);
                n_state = pidsc_pkg::S_ACC_I;
            end
            pidsc_pkg::S_ACC_I: begin
                n_state = pidsc_pkg::S_RND_I;
            end
            pidsc_pkg::S_RND_I: begin
                n_state = pidsc_pkg::S_INTEG;
            end
            pidsc_pkg::S_INTEG: begin
                n_state = pidsc_pkg::S_PI;
            end
            pidsc_pkg::S_PI: begin
                n_state = pidsc_pkg::S_SUM;
            end
            pidsc_pkg::S_SUM: begin
                if (w_fire) begin
                    n_state = pidsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pidsc_pkg::S_IDLE;
            end
        endcase
    end

    // Control and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= pidsc_pkg::GAIN_PROP_RST;
            r_gain_integ <= pidsc_pkg::GAIN_INTEG_RST;
            r_gain_deriv <= pidsc_pkg::GAIN_DERIV_RST;
            r_integrator <= '0;
            r_last_err   <= '0;
            r_d_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pidsc_pkg::CFG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                    pidsc_pkg::CFG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                    pidsc_pkg::CFG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_div_done) begin
                r_d_valid <= 1'b1;
            end else if (w_fire) begin
                r_d_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_last_err  <= r_err;
                // Anti-windup: the integrator holds while clamped or limited.
                if (!w_clamp && !r_lim) begin
                    r_integrator <= r_integ;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= ERR_W'(w_sp) - ERR_W'(w_pv);
            r_dt  <= (w_dt == '0) ? STEP_WIDTH'(1) : w_dt;
            r_lim <= i_in.limit_active;
        end
        case (r_state)
            pidsc_pkg::S_LOAD: begin
                r_em   <= r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
                r_eneg <= r_err[ERR_W-1];
                r_dem  <= w_de[DE_W-1] ? DE_W'(-w_de) : DE_W'(w_de);
                r_dneg <= w_de[DE_W-1];
            end
            pidsc_pkg::S_MUL_X: begin
                r_acc <= ACC_W'(w_prod);
            end
            pidsc_pkg::S_RND_P: begin
                r_p <= w_rnd_term;
                r_x <= X_W'(w_prod);
            end
            pidsc_pkg::S_MUL_IH: begin
                r_acc <= ACC_W'(w_prod);
            end
            pidsc_pkg::S_ACC_I: begin
                r_acc <= r_acc + (ACC_W'(w_prod) << MA_W);
            end
            pidsc_pkg::S_RND_I: begin
                r_inc <= w_rnd_term;
            end
            pidsc_pkg::S_INTEG: begin
                r_integ <= IW'(w_isat);
            end
            pidsc_pkg::S_PI: begin
                r_pi <= SUM_W'(r_p) + SUM_W'(r_integ);
            end
            default: begin
            end
        endcase
        if (w_fire) begin
            r_clamped <= w_clamp;
            if (w_clamp_hi) begin
                r_drive <= DRIVE_ONE;
            end else if (w_clamp_lo) begin
                r_drive <= DRIVE_NEG_ONE;
            end else begin
                r_drive <= DW'(w_sum);
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_drive;
    assign o_out.clamped = r_clamped;

    a_div_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state != pidsc_pkg::S_IDLE))
        else $error("divider running while the sequencer is idle");

    a_div_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> !r_d_valid)
        else $error("second derivative quotient for one item");

    a_windup_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_clamp) |=> $stable(r_integrator))
        else $error("integrator changed on a clamped result");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clamped) |->
            (o_out.drive == DRIVE_ONE || o_out.drive == DRIVE_NEG_ONE))
        else $error("clamped beat without a full-scale drive");

endmodule

@@ bench/pid_speed_controller_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pid_speed_controller_top: directed rows, then random control loops.
// Depends on pidsc_pkg, pidsc_chan_if and the controller RTL; predicts all untyped drive beats.
module pid_speed_controller_top_tb;
    import pidsc_pkg::*;

    localparam int SPD_W    = SPEED_WIDTH_DEF;
    localparam int STEP_W   = STEP_WIDTH_DEF;
    localparam int OUT_FRAC = OUT_FRAC_BITS_DEF;
    localparam int P_SHIFT  = GAIN_FRAC - OUT_FRAC;
    localparam int I_SHIFT  = DT_FRAC + GAIN_FRAC - OUT_FRAC;
    localparam int D_SHIFT  = OUT_FRAC - (DERIV_FRAC - DT_FRAC);
    localparam logic [127:0] TERM_SAT = 128'd1 << 56;
    localparam longint UNITY     = longint'(1) << OUT_FRAC;
    localparam longint INTEG_MAX = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN = -(longint'(1) << (INTEG_W - 1));
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam int SPD_MIN = -(1 << (SPD_W - 1));
    localparam int SPD_MAX = (1 << (SPD_W - 1)) - 1;
    localparam int STEP_MAX = (1 << STEP_W) - 1;
    localparam int N_DIRECTED = 17;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 155;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } drive_res_t;

    typedef struct packed {
        int ph;
        int sp;
        int pv;
        int dt;
        bit lim;
        bit typed;
        int drive;
        bit clamped;
    } drive_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [GAIN_W-1:0]    cfg_data;

    pidsc_in_if  in_ch ();
    pidsc_out_if out_ch ();

    pid_speed_controller_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state, mirrors the block's gains, integrator and stored error.
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    longint            integ_acc;
    longint            prev_err;

    drive_res_t pending_drive [$];
    drive_res_t want_r;
    drive_res_t got_r;
    drive_res_t typed_val;
    bit         typed_row;

    bit tx_gaps;
    bit rx_stalls;
    int rx_hold;
    int n_errors;
    int n_updates;
    int n_drives;
    int n_clamped;
    int n_settings;
    int track_base;
    int track_meas;

    drive_row_t       dir_rows [N_DIRECTED];
    logic [GAIN_W-1:0] dir_gains [3][3];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [127:0] shift_round_sat(logic [127:0] x, int sh);
        logic [127:0] r;
        r = (x + (128'd1 << (sh - 1))) >> sh;
        return (r > TERM_SAT) ? TERM_SAT : r;
    endfunction

    function automatic logic [127:0] div_round_sat(logic [127:0] num, logic [127:0] den);
        logic [127:0] q;
        logic [127:0] rem;
        q = num / den;
        rem = num % den;
        if ((rem << 1) >= den) q = q + 1;
        return (q > TERM_SAT) ? TERM_SAT : q;
    endfunction

    // One controller update: returns the drive beat and advances the state.
    function automatic drive_res_t pid_step(logic signed [SPD_W-1:0] sp,
                                            logic signed [SPD_W-1:0] pv,
                                            logic [STEP_W-1:0] dt, logic lim);
        longint       err;
        longint       de;
        longint       p;
        longint       inc;
        longint       integ;
        longint       d;
        longint       sum;
        logic [127:0] emag;
        logic [127:0] dmag;
        logic [127:0] den;
        drive_res_t   res;
        err = longint'(sp) - longint'(pv);
        de = err - prev_err;
        emag = (err < 0) ? 128'(-err) : 128'(err);
        dmag = (de < 0) ? 128'(-de) : 128'(de);
        den = (dt == '0) ? 128'd1 : 128'(dt);

        p = longint'(shift_round_sat(emag * gain_p, P_SHIFT));
        inc = longint'(shift_round_sat(emag * den * gain_i, I_SHIFT));
        d = longint'(div_round_sat((dmag * gain_d) << D_SHIFT, den));
        if (err < 0) begin
            p = -p;
            inc = -inc;
        end
        if (de < 0) d = -d;

        integ = integ_acc + inc;
        if (integ > INTEG_MAX) integ = INTEG_MAX;
        if (integ < INTEG_MIN) integ = INTEG_MIN;
        prev_err = err;

        sum = p + integ + d;
        res.clamped = 1'b1;
        if (sum > UNITY) begin
            sum = UNITY;
        end else if (sum < -UNITY) begin
            sum = -UNITY;
        end else begin
            res.clamped = 1'b0;
            // Anti-windup: the integrator only moves on unsaturated, unlimited updates.
            if (!lim) integ_acc = integ;
        end
        res.drive = sum[DRIVE_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH %s at %0t ns: got %0d, expected %0d", what, $time, got, want);
    endtask

    // Prediction on every accepted update beat, checking on every drive beat.
    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            want_r = pid_step(in_ch.setpoint, in_ch.measured, in_ch.time_step,
                              in_ch.limit_active);
            if (typed_row) want_r = typed_val;
            pending_drive.push_back(want_r);
            n_updates++;
        end
        if (out_ch.valid && out_ch.ready) begin
            got_r.drive = out_ch.drive;
            got_r.clamped = out_ch.clamped;
            n_drives++;
            if (got_r.clamped) n_clamped++;
            if (pending_drive.size() == 0) begin
                report_mismatch("unexpected drive beat", longint'(got_r.drive), 0);
            end else begin
                want_r = pending_drive.pop_front();
                if (got_r.drive !== want_r.drive)
                    report_mismatch("drive", longint'(got_r.drive), longint'(want_r.drive));
                if (got_r.clamped !== want_r.clamped)
                    report_mismatch("clamped", longint'(got_r.clamped),
                                    longint'(want_r.clamped));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off when requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d drive beats outstanding", pending_drive.size());
        $display("FAIL pid_speed_controller_top");
        $finish;
    end

    // Called at a falling edge; valid stays high after the beat until the next call.
    task automatic send_update(logic signed [SPD_W-1:0] sp, logic signed [SPD_W-1:0] pv,
                               logic [STEP_W-1:0] dt, logic lim);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.setpoint <= sp;
        in_ch.measured <= pv;
        in_ch.time_step <= dt;
        in_ch.limit_active <= lim;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_drives();
        in_ch.valid <= 1'b0;
        while (pending_drive.size() != 0) @(negedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic program_gains(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                                 logic [GAIN_W-1:0] gd, bit poke_spare);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_GAIN_PROP;
        cfg_data <= gp;
        @(negedge i_clk);
        cfg_idx <= CFG_GAIN_INTEG;
        cfg_data <= gi;
        @(negedge i_clk);
        cfg_idx <= CFG_GAIN_DERIV;
        cfg_data <= gd;
        @(negedge i_clk);
        if (poke_spare) begin
            // Writes past the last gain must leave everything alone.
            cfg_idx <= CFG_SPARE;
            cfg_data <= $urandom;
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        gain_p = gp;
        gain_i = gi;
        gain_d = gd;
        n_settings++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] nominal);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return $urandom;
            3:       return GAIN_W'($urandom_range(0, 1 << 20));
            default: return GAIN_W'(($urandom_range(1, 40) * longint'(nominal)) >> 3);
        endcase
    endfunction

    // Mostly a plant that converges on its setpoint, with noise and corner beats mixed in.
    task automatic next_random_update(output logic signed [SPD_W-1:0] sp,
                                      output logic signed [SPD_W-1:0] pv,
                                      output logic [STEP_W-1:0] dt, output logic lim);
        int pick;
        int corner [4];
        corner = '{SPD_MIN, SPD_MAX, 0, -1};
        pick = $urandom_range(0, 99);
        lim = ($urandom_range(0, 7) == 0);
        if (pick < 70) begin
            if ($urandom_range(0, 39) == 0)
                track_base = int'($urandom_range(0, 1000000)) - 500000;
            track_meas = track_meas + (track_base - track_meas) / 8
                         + int'($urandom_range(0, 200)) - 100;
            if (track_meas > SPD_MAX) track_meas = SPD_MAX;
            if (track_meas < SPD_MIN) track_meas = SPD_MIN;
            sp = SPD_W'(track_base);
            pv = SPD_W'(track_meas);
            dt = STEP_W'($urandom_range(8000, 40000));
        end else if (pick < 90) begin
            sp = SPD_W'($urandom);
            pv = SPD_W'($urandom);
            dt = STEP_W'($urandom_range(1, STEP_MAX));
        end else begin
            sp = SPD_W'(corner[$urandom_range(0, 3)]);
            pv = SPD_W'(corner[$urandom_range(0, 3)]);
            case ($urandom_range(0, 2))
                0:       dt = STEP_W'(1);
                1:       dt = STEP_W'(STEP_MAX);
                default: dt = STEP_W'($urandom_range(1, 16));
            endcase
        end
    endtask

    initial begin
        logic signed [SPD_W-1:0] sp;
        logic signed [SPD_W-1:0] pv;
        logic [STEP_W-1:0]       dt;
        logic                    lim;
        int                      cur_ph;

        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_GAIN_PROP;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.setpoint = '0;
        in_ch.measured = '0;
        in_ch.time_step = STEP_W'(1);
        in_ch.limit_active = 1'b0;
        gain_p = GAIN_PROP_RST;
        gain_i = GAIN_INTEG_RST;
        gain_d = GAIN_DERIV_RST;
        integ_acc = 0;
        prev_err = 0;
        typed_row = 1'b0;
        typed_val = '0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        rx_hold = 0;
        n_errors = 0;
        n_updates = 0;
        n_drives = 0;
        n_clamped = 0;
        n_settings = 1;
        track_base = 1500;
        track_meas = 0;

        // Phase 1 drives the integrator into both 40-bit bounds while the
        // derivative term cancels it; phase 2 pulls it back near zero.
        dir_gains = '{'{GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST},
                      '{'0, GAIN_MAX, GAIN_MAX},
                      '{'0, GAIN_MAX, '0}};
        dir_rows = '{
            '{0, 0, 0, 1, 1'b0, 1'b1, 0, 1'b0},
            '{0, SPD_MAX, SPD_MIN, STEP_MAX, 1'b0, 1'b1, int'(UNITY), 1'b1},
            '{0, SPD_MIN, SPD_MAX, 1, 1'b1, 1'b1, -int'(UNITY), 1'b1},
            '{0, 100, 100, 16777, 1'b0, 1'b0, 0, 1'b0},
            '{0, 1000, 900, 16777, 1'b0, 1'b0, 0, 1'b0},
            '{0, 900, 1000, 16777, 1'b1, 1'b0, 0, 1'b0},
            '{0, -1, 0, 1, 1'b0, 1'b0, 0, 1'b0},
            '{0, 0, -1, STEP_MAX, 1'b0, 1'b0, 0, 1'b0},
            '{0, SPD_MAX, SPD_MAX, 8388608, 1'b0, 1'b0, 0, 1'b0},
            '{0, SPD_MIN, SPD_MIN, 5592405, 1'b1, 1'b0, 0, 1'b0},
            '{0, 349525, -349526, 11184810, 1'b0, 1'b0, 0, 1'b0},
            '{1, SPD_MAX, SPD_MIN, 262143, 1'b0, 1'b0, 0, 1'b0},
            '{1, SPD_MAX, -1, 262143, 1'b0, 1'b0, 0, 1'b0},
            '{1, SPD_MIN, SPD_MAX, 262143, 1'b0, 1'b0, 0, 1'b0},
            '{1, SPD_MIN, 0, 262143, 1'b0, 1'b0, 0, 1'b0},
            '{2, SPD_MAX, -1, 16384, 1'b0, 1'b0, 0, 1'b0},
            '{2, 0, 0, 1, 1'b1, 1'b0, 0, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        cur_ph = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].ph != cur_ph) begin
                drain_drives();
                cur_ph = dir_rows[r].ph;
                program_gains(dir_gains[cur_ph][0], dir_gains[cur_ph][1],
                              dir_gains[cur_ph][2], cur_ph == 1);
            end
            typed_row = dir_rows[r].typed;
            typed_val.drive = dir_rows[r].drive;
            typed_val.clamped = dir_rows[r].clamped;
            send_update(SPD_W'(dir_rows[r].sp), SPD_W'(dir_rows[r].pv),
                        STEP_W'(dir_rows[r].dt), dir_rows[r].lim);
        end
        typed_row = 1'b0;
        drain_drives();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
                1:       program_gains('0, '0, '0, 1'b0);
                2:       program_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, 1'b1);
                default: program_gains(pick_gain(GAIN_PROP_RST), pick_gain(GAIN_INTEG_RST),
                                       pick_gain(GAIN_DERIV_RST), 1'b0);
            endcase
            // The receiver sits out long enough for the input to back up.
            if (ph == 3) rx_hold = 300;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == N_PHASES - 1) begin
                    tx_gaps = 1'b0;
                    rx_stalls = 1'b0;
                end else if (n % 50 == 0) begin
                    tx_gaps = ($urandom_range(0, 2) != 0);
                    rx_stalls = ($urandom_range(0, 2) != 0);
                end
                next_random_update(sp, pv, dt, lim);
                send_update(sp, pv, dt, lim);
            end
            drain_drives();
        end

        repeat (60) @(negedge i_clk);
        $display("Ran %0d controller updates under %0d gain settings; %0d of %0d drives clamped.",
                 n_updates, n_settings, n_clamped, n_drives);
        $display("Stimulus covered field extremes, integrator saturation and receiver back-pressure.");
        if (n_errors == 0) begin
            $display("PASS pid_speed_controller_top");
        end else begin
            $display("FAIL pid_speed_controller_top");
        end
        $finish;
    end

endmodule
